// File: rtl/core/vtll_pkg.sv
// types and constants shared by the letterbox layout block
package vtll_pkg;

	localparam int COORD_W    = 13;
	localparam int ASP_W      = 8;
	localparam int LUMA_W     = 24;
	localparam int CHROMA_W   = 22;
	localparam int COLOUR_W   = 8;
	localparam int CFG_IDX_W  = 3;
	// aspect-scaled source size
	localparam int ASP_PROD_W = COORD_W + ASP_W;
	// products of the letterbox compare
	localparam int FIT_W      = ASP_PROD_W + COORD_W;
	// left edge can run past the frame for out-of-range tile indexes
	localparam int LEFT_W     = 18;
	localparam int TOP_W      = 14;

	localparam logic CMD_LISTENER = 1'b0;
	localparam logic CMD_SPEAKER  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIX_WIDTH   = 3'd0,
		CFG_MIX_HEIGHT  = 3'd1,
		CFG_LIS_ASP_NUM = 3'd2,
		CFG_LIS_ASP_DEN = 3'd3,
		CFG_SPK_ASP_NUM = 3'd4,
		CFG_SPK_ASP_DEN = 3'd5
	} cfg_reg_t;

	localparam logic [COORD_W-1:0] MIX_WIDTH_RST  = 13'd640;
	localparam logic [COORD_W-1:0] MIX_HEIGHT_RST = 13'd480;
	localparam logic [ASP_W-1:0]   ASP_RST        = 8'd1;

	// border colours
	localparam logic [COLOUR_W-1:0] BLUE_Y  = 8'd29;
	localparam logic [COLOUR_W-1:0] BLUE_U  = 8'd255;
	localparam logic [COLOUR_W-1:0] BLUE_V  = 8'd107;
	localparam logic [COLOUR_W-1:0] GREEN_Y = 8'd149;
	localparam logic [COLOUR_W-1:0] GREEN_U = 8'd43;
	localparam logic [COLOUR_W-1:0] GREEN_V = 8'd21;

	typedef struct packed {
		logic               command;
		logic [4:0]         participant_count;
		logic [3:0]         tile_index;
		logic [COORD_W-1:0] source_width;
		logic [COORD_W-1:0] source_height;
		logic               is_speaker;
		logic               is_speaking;
	} vtll_in_t;

	typedef struct packed {
		logic [COORD_W-1:0]  rect_left;
		logic [COORD_W-1:0]  rect_top;
		logic [COORD_W-1:0]  rect_width;
		logic [COORD_W-1:0]  rect_height;
		logic [LUMA_W-1:0]   luma_offset;
		logic [CHROMA_W-1:0] chroma_offset;
		logic                border_enable;
		logic [COLOUR_W-1:0] border_y;
		logic [COLOUR_W-1:0] border_u;
		logic [COLOUR_W-1:0] border_v;
	} vtll_out_t;

endpackage

// File: rtl/core/vtll_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module vtll_div_pipe #(
	parameter int NW = 21,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [NW-1:0] quotient
);

	logic [DW-1:0] rem_s [NW-1];
	logic [DW-1:0] dvs_s [NW-1];
	logic [NW-1:0] quo_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [DW-1:0] dvs_in;
		logic [NW-1:0] quo_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          fits;

		// stage inputs
		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign dvs_in = divisor;
			assign quo_in = dividend;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// shift in next dividend bit and try the subtract
		assign trial = {rem_in, quo_in[NW-1]};
		assign diff  = trial - {1'b0, dvs_in};
		assign fits  = trial >= {1'b0, dvs_in};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_in[NW-2:0], fits};
			end
		end

		if (k < NW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= fits ? diff[DW-1:0] : trial[DW-1:0];
					dvs_s[k] <= dvs_in;
				end
			end
		end
	end

	assign quotient = quo_s[NW-1];

endmodule

// File: rtl/core/vtll_delay.sv
// delay line that keeps side data in step with a divider pipe
module vtll_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_tap
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				line_q[k] <= '0;
			end else if (en) begin
				line_q[k] <= (k == 0) ? d : line_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

// File: rtl/core/video_tile_letterbox_layout_core.sv
// letterbox placement of a source picture in a yuv420 compositor frame
//
//   channel | direction | handshake         | beat
//   --------+-----------+-------------------+-------------------------
//   cfg     | in        | cfg_we            | cfg_index, cfg_wdata
//   in      | in        | in_valid/in_stall | in_data (vtll_in_t)
//   out     | out       | out_valid/out_stall | out_data (vtll_out_t)
//
// one beat enters per cycle while in_stall is low; each passes through
// two divider pipes in turn (21 and 34 stages).
// reset clears the valid bits and loads the register defaults.
// a stall on a valid output beat freezes every stage at once, so nothing
// is lost or repeated; in_stall follows the output register's state.
module video_tile_letterbox_layout_core import vtll_pkg::*; #(
	parameter int MAX_PARTICIPANTS  = 16,
	parameter int MIN_SLOTS         = 4,
	parameter int STRIP_HEIGHT_LOG2 = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  vtll_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output vtll_out_t            out_data
);

	localparam int SLOT_MAX = (MAX_PARTICIPANTS > MIN_SLOTS) ? MAX_PARTICIPANTS : MIN_SLOTS;
	localparam int SLOT_BITS = $clog2(SLOT_MAX + 1);
	localparam int CNT_W = (SLOT_BITS > 5) ? SLOT_BITS : 5;
	localparam int STRIPW_W = CNT_W + COORD_W;
	localparam int ROW_W = TOP_W + COORD_W;

	typedef struct packed {
		logic               command;
		logic [CNT_W-1:0]   cnt;
		logic [3:0]         tile_index;
		logic [COORD_W-1:0] sw;
		logic [COORD_W-1:0] sh;
		logic               spk;
		logic               talk;
		logic               wide;
		logic               tall;
		logic               skip;
	} st1_t;

	typedef struct packed {
		logic                  command;
		logic [LEFT_W-1:0]     left;
		logic [COORD_W-1:0]    w;
		logic [COORD_W-1:0]    h;
		logic [ASP_PROD_W-1:0] sw;
		logic [ASP_PROD_W-1:0] sh;
		logic                  skip;
		logic                  spk;
		logic                  talk;
	} st2_t;

	typedef struct packed {
		logic               command;
		logic [LEFT_W-1:0]  left;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
		logic               skip;
		logic               spk;
		logic               talk;
		logic               fit_h;
	} st4_t;

	typedef struct packed {
		logic [LEFT_W-1:0]   left;
		logic [TOP_W-1:0]    top;
		logic [COORD_W-1:0]  w;
		logic [COORD_W-1:0]  h;
		logic                ben;
		logic [COLOUR_W-1:0] by;
		logic [COLOUR_W-1:0] bu;
		logic [COLOUR_W-1:0] bv;
	} st5_t;

	// configuration registers
	logic [COORD_W-1:0] mix_width_q, mix_height_q;
	logic [ASP_W-1:0]   lis_num_q, lis_den_q, spk_num_q, spk_den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_width_q  <= MIX_WIDTH_RST;
			mix_height_q <= MIX_HEIGHT_RST;
			lis_num_q    <= ASP_RST;
			lis_den_q    <= ASP_RST;
			spk_num_q    <= ASP_RST;
			spk_den_q    <= ASP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIX_WIDTH:   mix_width_q  <= cfg_wdata;
				CFG_MIX_HEIGHT:  mix_height_q <= cfg_wdata;
				CFG_LIS_ASP_NUM: lis_num_q    <= cfg_wdata[ASP_W-1:0];
				CFG_LIS_ASP_DEN: lis_den_q    <= cfg_wdata[ASP_W-1:0];
				CFG_SPK_ASP_NUM: spk_num_q    <= cfg_wdata[ASP_W-1:0];
				CFG_SPK_ASP_DEN: spk_den_q    <= cfg_wdata[ASP_W-1:0];
				default: ;
			endcase
		end
	end

	// strip and region heights
	logic [COORD_W-1:0] strip_h, region_h;
	assign strip_h  = mix_height_q >> STRIP_HEIGHT_LOG2;
	assign region_h = mix_height_q - strip_h;

	// whole pipe advances together
	logic      adv;
	logic      out_valid_q;
	vtll_out_t out_data_q;
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// stage 1: slot count, aspect selection and scaling product
	logic [ASP_W-1:0]      num_c, den_c;
	logic                  wide_c, tall_c, skip_c;
	logic [COORD_W-1:0]    mul_a_c;
	logic [ASP_W-1:0]      mul_b_c;
	logic [CNT_W-1:0]      cnt_ext_c, cnt_sat_c, slots_c;
	st1_t                  st1_c;

	always_comb begin
		num_c   = (in_data.command == CMD_SPEAKER) ? spk_num_q : lis_num_q;
		den_c   = (in_data.command == CMD_SPEAKER) ? spk_den_q : lis_den_q;
		wide_c  = num_c > den_c;
		tall_c  = num_c < den_c;
		skip_c  = (num_c == '0) || (den_c == '0) ||
			(in_data.source_width == '0) || (in_data.source_height == '0);
		mul_a_c = wide_c ? in_data.source_width : in_data.source_height;
		mul_b_c = wide_c ? num_c : den_c;
		cnt_ext_c = CNT_W'(in_data.participant_count);
		cnt_sat_c = (cnt_ext_c > CNT_W'(MAX_PARTICIPANTS)) ? CNT_W'(MAX_PARTICIPANTS)
			: cnt_ext_c;
		slots_c = (cnt_sat_c > CNT_W'(MIN_SLOTS)) ? cnt_sat_c : CNT_W'(MIN_SLOTS);
		st1_c.command    = in_data.command;
		st1_c.cnt        = cnt_sat_c;
		st1_c.tile_index = in_data.tile_index;
		st1_c.sw         = in_data.source_width;
		st1_c.sh         = in_data.source_height;
		st1_c.spk        = in_data.is_speaker;
		st1_c.talk       = in_data.is_speaking;
		st1_c.wide       = wide_c;
		st1_c.tall       = tall_c;
		st1_c.skip       = skip_c;
	end

	logic                  valid_s1;
	st1_t                  st_s1;
	logic [CNT_W-1:0]      slots_s1;
	logic [ASP_PROD_W-1:0] asp_prod_s1;
	logic [ASP_W-1:0]      asp_dvs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1       <= st1_c;
			slots_s1    <= slots_c;
			asp_prod_s1 <= ASP_PROD_W'(mul_a_c) * ASP_PROD_W'(mul_b_c);
			asp_dvs_s1  <= wide_c ? den_c : num_c;
		end
	end

	// slot width and aspect quotient
	logic [ASP_PROD_W-1:0] slot_q, asp_q;
	logic                  valid_d1;
	st1_t                  st_d1;

	vtll_div_pipe #(.NW(ASP_PROD_W), .DW(CNT_W)) u_slot_div (
		.clk(clk), .en(adv), .dividend(ASP_PROD_W'(mix_width_q)), .divisor(slots_s1),
		.quotient(slot_q)
	);

	vtll_div_pipe #(.NW(ASP_PROD_W), .DW(ASP_W)) u_asp_div (
		.clk(clk), .en(adv), .dividend(asp_prod_s1), .divisor(asp_dvs_s1),
		.quotient(asp_q)
	);

	vtll_delay #(.W(1), .DEPTH(ASP_PROD_W)) u_vld_d1 (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(valid_s1), .q(valid_d1)
	);

	vtll_delay #(.W($bits(st1_t)), .DEPTH(ASP_PROD_W)) u_st_d1 (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(st_s1), .q(st_d1)
	);

	// stage 2: slot box and corrected source size
	logic [COORD_W-1:0]  slot_w_c;
	logic [STRIPW_W-1:0] strip_w_c;
	logic [16:0]         idx_off_c;
	logic [LEFT_W-1:0]   left_l_c;
	st2_t                st2_c;

	always_comb begin
		slot_w_c  = slot_q[COORD_W-1:0];
		strip_w_c = STRIPW_W'(st_d1.cnt) * STRIPW_W'(slot_w_c);
		idx_off_c = 17'(st_d1.tile_index) * 17'(slot_w_c);
		left_l_c  = LEFT_W'(mix_width_q >> 1) - LEFT_W'(strip_w_c >> 1) + LEFT_W'(idx_off_c);
		st2_c.command = st_d1.command;
		st2_c.sw      = st_d1.wide ? asp_q : ASP_PROD_W'(st_d1.sw);
		st2_c.sh      = st_d1.tall ? asp_q : ASP_PROD_W'(st_d1.sh);
		st2_c.skip    = st_d1.skip;
		st2_c.spk     = st_d1.spk;
		st2_c.talk    = st_d1.talk;
		if (st_d1.command == CMD_LISTENER) begin
			st2_c.left = left_l_c;
			st2_c.w    = slot_w_c;
			st2_c.h    = strip_h;
		end else begin
			st2_c.left = '0;
			st2_c.w    = mix_width_q;
			st2_c.h    = region_h;
		end
	end

	logic valid_s2;
	st2_t st_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s2 <= st2_c;
		end
	end

	// stage 3: cross products for the letterbox compare
	logic             valid_s3;
	st2_t             st_s3;
	logic [FIT_W-1:0] prod_a_s3, prod_b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s3     <= st_s2;
			prod_a_s3 <= FIT_W'(st_s2.sw) * FIT_W'(st_s2.h);
			prod_b_s3 <= FIT_W'(st_s2.w) * FIT_W'(st_s2.sh);
		end
	end

	// stage 4: full-height fit when sw*h < (w+1)*sh, pick the division
	logic fit_h_c;
	st4_t st4_c;

	always_comb begin
		fit_h_c = {1'b0, prod_a_s3} < ({1'b0, prod_b_s3} + (FIT_W+1)'(st_s3.sh));
		st4_c.command = st_s3.command;
		st4_c.left    = st_s3.left;
		st4_c.w       = st_s3.w;
		st4_c.h       = st_s3.h;
		st4_c.skip    = st_s3.skip;
		st4_c.spk     = st_s3.spk;
		st4_c.talk    = st_s3.talk;
		st4_c.fit_h   = fit_h_c;
	end

	logic                  valid_s4;
	st4_t                  st_s4;
	logic [FIT_W-1:0]      fit_dvd_s4;
	logic [ASP_PROD_W-1:0] fit_dvs_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s4      <= st4_c;
			fit_dvd_s4 <= fit_h_c ? prod_a_s3 : prod_b_s3;
			fit_dvs_s4 <= fit_h_c ? st_s3.sh : st_s3.sw;
		end
	end

	// letterboxed side
	logic [FIT_W-1:0] fit_q;
	logic             valid_d2;
	st4_t             st_d2;

	vtll_div_pipe #(.NW(FIT_W), .DW(ASP_PROD_W)) u_fit_div (
		.clk(clk), .en(adv), .dividend(fit_dvd_s4), .divisor(fit_dvs_s4), .quotient(fit_q)
	);

	vtll_delay #(.W(1), .DEPTH(FIT_W)) u_vld_d2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(valid_s4), .q(valid_d2)
	);

	vtll_delay #(.W($bits(st4_t)), .DEPTH(FIT_W)) u_st_d2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(st_s4), .q(st_d2)
	);

	// stage 5: centre, round down to even, border colour
	logic [COORD_W-1:0] lw_c, lh_c;
	logic [COORD_W-1:0] dw_c, dh_c;
	logic [LEFT_W-1:0]  left5_c;
	logic [TOP_W-1:0]   top5_c;
	st5_t               st5_c;

	always_comb begin
		if (st_d2.skip) begin
			lw_c = st_d2.w;
			lh_c = st_d2.h;
		end else if (st_d2.fit_h) begin
			lw_c = fit_q[COORD_W-1:0];
			lh_c = st_d2.h;
		end else begin
			lw_c = st_d2.w;
			lh_c = fit_q[COORD_W-1:0];
		end
		dw_c    = st_d2.w - lw_c;
		dh_c    = st_d2.h - lh_c;
		left5_c = st_d2.left + LEFT_W'(dw_c >> 1);
		top5_c  = TOP_W'(dh_c >> 1);
		st5_c.left = {left5_c[LEFT_W-1:1], 1'b0};
		st5_c.top  = {top5_c[TOP_W-1:1], 1'b0};
		st5_c.w    = lw_c;
		st5_c.h    = lh_c;
		st5_c.ben  = 1'b0;
		st5_c.by   = '0;
		st5_c.bu   = '0;
		st5_c.bv   = '0;
		if (st_d2.command == CMD_LISTENER) begin
			st5_c.top = {top5_c[TOP_W-1:1], 1'b0} + TOP_W'(region_h);
			if (st_d2.spk) begin
				st5_c.ben = 1'b1;
				st5_c.by  = BLUE_Y;
				st5_c.bu  = BLUE_U;
				st5_c.bv  = BLUE_V;
			end else if (st_d2.talk) begin
				st5_c.ben = 1'b1;
				st5_c.by  = GREEN_Y;
				st5_c.bu  = GREEN_U;
				st5_c.bv  = GREEN_V;
			end
		end
	end

	logic valid_s5;
	st5_t st_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s5 <= st5_c;
		end
	end

	// stage 6: luma row offset
	logic              valid_s6;
	st5_t              st_s6;
	logic [ROW_W-1:0]  row_c;
	logic [LUMA_W-1:0] row_s6;

	assign row_c = ROW_W'(st_s5.top) * ROW_W'(mix_width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s6  <= st_s5;
			row_s6 <= row_c[LUMA_W-1:0];
		end
	end

	// output register: plane offsets and result beat
	vtll_out_t out_c;

	always_comb begin
		out_c.rect_left     = st_s6.left[COORD_W-1:0];
		out_c.rect_top      = st_s6.top[COORD_W-1:0];
		out_c.rect_width    = st_s6.w;
		out_c.rect_height   = st_s6.h;
		out_c.luma_offset   = row_s6 + LUMA_W'(st_s6.left);
		out_c.chroma_offset = row_s6[LUMA_W-1:2] + CHROMA_W'(st_s6.left >> 1);
		out_c.border_enable = st_s6.ben;
		out_c.border_y      = st_s6.by;
		out_c.border_u      = st_s6.bu;
		out_c.border_v      = st_s6.bv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= out_c;
		end
	end

endmodule

// File: dv/tb.sv
// self-checking testbench for the letterbox layout core
module tb;
	import vtll_pkg::*;

	localparam int LATENCY    = 62;
	localparam int N_RANDOM   = 1550;
	localparam int CYCLE_CAP  = 1000000;
	localparam int IN_W       = $bits(vtll_in_t);

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_wdata;
	logic      in_valid;
	logic      in_stall;
	vtll_in_t  in_data;
	logic      out_valid;
	logic      out_stall;
	vtll_out_t out_data;

	int errors;
	int cycles;

	// shadow of the layout registers
	logic [12:0] mw, mh;
	logic [7:0]  lnum, lden, snum, sden;

	video_tile_letterbox_layout_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0d want %0d", what, got, want);
	endtask

	// letterbox a source into a box, full precision
	function automatic void fit(inout longint unsigned l, t, w, h,
			input longint unsigned sw0, sh0, num, den);
		longint unsigned sw, sh, lw, lh;
		sw = sw0;
		sh = sh0;
		if (num == 0 || den == 0 || sw == 0 || sh == 0) return;
		if (num > den) sw = sw * num / den;
		else if (num < den) sh = sh * den / num;
		if (sw * h / sh <= w) begin
			lw = h * sw / sh;
			lh = h;
		end else begin
			lw = w;
			lh = w * sh / sw;
		end
		l = l + ((w - lw) >> 1);
		t = t + ((h - lh) >> 1);
		w = lw;
		h = lh;
	endfunction

	function automatic vtll_out_t place(vtll_in_t b);
		vtll_out_t r;
		longint unsigned strip_h, region_h, l, t, w, h, cnt, slots, slot_w, row, left, top;
		strip_h = mh >> 2;
		region_h = mh - strip_h;
		r = '0;
		if (b.command == CMD_LISTENER) begin
			cnt = b.participant_count;
			if (cnt > 16) cnt = 16;
			slots = cnt > 4 ? cnt : 4;
			slot_w = mw / slots;
			l = (mw >> 1) - ((cnt * slot_w) >> 1) + b.tile_index * slot_w;
			t = 0;
			w = slot_w;
			h = strip_h;
			fit(l, t, w, h, b.source_width, b.source_height, lnum, lden);
			left = l & ~64'd1;
			top = (t & ~64'd1) + region_h;
			if (b.is_speaker) begin
				r.border_enable = 1'b1;
				r.border_y = BLUE_Y; r.border_u = BLUE_U; r.border_v = BLUE_V;
			end else if (b.is_speaking) begin
				r.border_enable = 1'b1;
				r.border_y = GREEN_Y; r.border_u = GREEN_U; r.border_v = GREEN_V;
			end
		end else begin
			l = 0; t = 0; w = mw; h = region_h;
			fit(l, t, w, h, b.source_width, b.source_height, snum, sden);
			left = l & ~64'd1;
			top = t & ~64'd1;
		end
		row = top * mw;
		r.rect_left = left[12:0];
		r.rect_top = top[12:0];
		r.rect_width = w[12:0];
		r.rect_height = h[12:0];
		r.luma_offset = 24'(row + left);
		r.chroma_offset = 22'((row >> 2) + (left >> 1));
		return r;
	endfunction

	class placement_board;
		vtll_out_t pending[$];
		function void note_beat(vtll_out_t e);
			pending.push_back(e);
		endfunction
		task check_beat(vtll_out_t g);
			vtll_out_t e;
			if (pending.size() == 0) begin
				report("unexpected beat", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (g.rect_left != e.rect_left) report("rect_left", g.rect_left, e.rect_left);
			if (g.rect_top != e.rect_top) report("rect_top", g.rect_top, e.rect_top);
			if (g.rect_width != e.rect_width) report("rect_width", g.rect_width, e.rect_width);
			if (g.rect_height != e.rect_height)
				report("rect_height", g.rect_height, e.rect_height);
			if (g.luma_offset != e.luma_offset)
				report("luma_offset", g.luma_offset, e.luma_offset);
			if (g.chroma_offset != e.chroma_offset)
				report("chroma_offset", g.chroma_offset, e.chroma_offset);
			if (g.border_enable != e.border_enable)
				report("border_enable", g.border_enable, e.border_enable);
			if (g.border_y != e.border_y) report("border_y", g.border_y, e.border_y);
			if (g.border_u != e.border_u) report("border_u", g.border_u, e.border_u);
			if (g.border_v != e.border_v) report("border_v", g.border_v, e.border_v);
		endtask
	endclass

	placement_board board = new();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// phase without idling sometimes
	bit busy_mode;

	// result side: random stall, check each beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) board.check_beat(out_data);
			out_stall <= busy_mode ? 1'b0 : ($urandom_range(0, 99) < 25 ?
				1'b1 : ($urandom_range(0, 99) < 3));
		end
	end

	// timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [12:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MIX_WIDTH:   mw = v;
			CFG_MIX_HEIGHT:  mh = v;
			CFG_LIS_ASP_NUM: lnum = v[7:0];
			CFG_LIS_ASP_DEN: lden = v[7:0];
			CFG_SPK_ASP_NUM: snum = v[7:0];
			default:         sden = v[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// send one beat, holding it until accepted
	task automatic send(input vtll_in_t b);
		int g;
		g = busy_mode ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_beat(place(b));
	endtask

	task automatic send_fields(input logic c, input logic [4:0] n, input logic [3:0] ix,
			input logic [12:0] sw, input logic [12:0] sh, input logic spk, input logic tk);
		vtll_in_t b;
		b.command = c; b.participant_count = n; b.tile_index = ix;
		b.source_width = sw; b.source_height = sh; b.is_speaker = spk; b.is_speaking = tk;
		send(b);
	endtask

	function automatic logic [12:0] rand_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 5) return 13'd0;
		if (p < 10) return 13'(4096 + $urandom_range(0, 4095));
		if (p < 20) return 13'd4096;
		return 13'($urandom_range(1, 4096));
	endfunction

	function automatic logic [7:0] rand_asp();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return 8'd0;
		if (p == 1) return 8'd255;
		if (p == 2) return 8'd1;
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic random_items(input int n);
		vtll_in_t b;
		for (int i = 0; i < n; i++) begin
			b = IN_W'({$urandom, $urandom});
			b.source_width = rand_size();
			b.source_height = rand_size();
			if ($urandom_range(0, 9) < 8)
				b.participant_count = 5'($urandom_range(1, 16));
			send(b);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		logic [12:0] wv, hv;
		clk = 1'b0;
		errors = 0;
		cycles = 0;
		busy_mode = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		mw = MIX_WIDTH_RST; mh = MIX_HEIGHT_RST;
		lnum = ASP_RST; lden = ASP_RST; snum = ASP_RST; sden = ASP_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, field extremes, borders, zero sizes, odd counts
		send_fields(CMD_LISTENER, 5'd1, 4'd0, 13'd640, 13'd480, 1'b0, 1'b0);
		send_fields(CMD_LISTENER, 5'd4, 4'd3, 13'd1920, 13'd1080, 1'b1, 1'b0);
		send_fields(CMD_LISTENER, 5'd16, 4'd15, 13'd4096, 13'd1, 1'b0, 1'b1);
		send_fields(CMD_LISTENER, 5'd31, 4'd15, 13'd1, 13'd4096, 1'b1, 1'b1);
		send_fields(CMD_LISTENER, 5'd0, 4'd2, 13'd320, 13'd240, 1'b0, 1'b1);
		send_fields(CMD_LISTENER, 5'd2, 4'd9, 13'd0, 13'd240, 1'b0, 1'b0);
		send_fields(CMD_LISTENER, 5'd7, 4'd1, 13'd320, 13'd0, 1'b1, 1'b0);
		send_fields(CMD_SPEAKER, 5'd31, 4'd15, 13'd1280, 13'd720, 1'b1, 1'b1);
		send_fields(CMD_SPEAKER, 5'd0, 4'd0, 13'd0, 13'd0, 1'b0, 1'b0);
		send_fields(CMD_SPEAKER, 5'd3, 4'd5, 13'h1FFF, 13'h1FFF, 1'b0, 1'b1);
		send_fields(CMD_SPEAKER, 5'd1, 4'd0, 13'd1, 13'd4096, 1'b0, 1'b0);
		in_valid <= 1'b0;
		drain();
		write_reg(CFG_LIS_ASP_NUM, 13'd255);
		write_reg(CFG_LIS_ASP_DEN, 13'd1);
		write_reg(CFG_SPK_ASP_NUM, 13'd1);
		write_reg(CFG_SPK_ASP_DEN, 13'd255);
		send_fields(CMD_LISTENER, 5'd5, 4'd4, 13'd4096, 13'd4096, 1'b0, 1'b1);
		send_fields(CMD_SPEAKER, 5'd5, 4'd4, 13'd4096, 13'd4096, 1'b0, 1'b0);
		send_fields(CMD_SPEAKER, 5'd5, 4'd4, 13'd1, 13'd1, 1'b0, 1'b0);
		in_valid <= 1'b0;
		drain();
		write_reg(CFG_MIX_WIDTH, 13'd4096);
		write_reg(CFG_MIX_HEIGHT, 13'd4096);
		write_reg(CFG_LIS_ASP_NUM, 13'd0);
		write_reg(CFG_SPK_ASP_DEN, 13'd0);
		send_fields(CMD_LISTENER, 5'd16, 4'd15, 13'd4096, 13'd17, 1'b1, 1'b0);
		send_fields(CMD_SPEAKER, 5'd1, 4'd0, 13'd17, 13'd4096, 1'b0, 1'b0);
		in_valid <= 1'b0;
		drain();
		write_reg(CFG_MIX_WIDTH, 13'd16);
		write_reg(CFG_MIX_HEIGHT, 13'd16);
		write_reg(CFG_LIS_ASP_NUM, 13'd3);
		write_reg(CFG_LIS_ASP_DEN, 13'd7);
		write_reg(CFG_SPK_ASP_DEN, 13'd3);
		send_fields(CMD_LISTENER, 5'd16, 4'd15, 13'd4096, 13'd4096, 1'b0, 1'b1);
		send_fields(CMD_SPEAKER, 5'd1, 4'd0, 13'd4096, 13'd1, 1'b0, 1'b0);
		in_valid <= 1'b0;
		drain();

		// random phases under random settings
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin wv = 13'd640; hv = 13'd480; end
				1: begin wv = 13'd4096; hv = 13'd4096; end
				2: begin wv = 13'd16; hv = 13'd16; end
				3: begin wv = 13'h1FFF; hv = 13'h1FFF; end
				default: begin
					wv = 13'($urandom_range(16, 4096));
					hv = 13'($urandom_range(16, 4096));
				end
			endcase
			write_reg(CFG_MIX_WIDTH, wv);
			write_reg(CFG_MIX_HEIGHT, hv);
			write_reg(CFG_LIS_ASP_NUM, 13'(rand_asp()));
			write_reg(CFG_LIS_ASP_DEN, 13'(rand_asp()));
			write_reg(CFG_SPK_ASP_NUM, 13'(rand_asp()));
			write_reg(CFG_SPK_ASP_DEN, 13'(rand_asp()));
			busy_mode = (ph % 4 == 3);
			random_items(N_RANDOM / 10);
			drain();
			busy_mode = 1'b0;
		end

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// File: filelist.f
rtl/core/vtll_pkg.sv
rtl/core/vtll_div_pipe.sv
rtl/core/vtll_delay.sv
rtl/core/video_tile_letterbox_layout_core.sv
dv/tb.sv
